// ===== design/vi_pkg.sv =====
// vi_pkg: shared types, constants and helper functions for the vortex indicator
// holds item structs, ring entry type, sequencer states and price helpers
// no dependencies; imported by vortex_indicator
package vi_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int FIELD_W        = 32;
    localparam int PRICE_BITS     = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int INT_BITS       = 4;
    localparam int OUT_W          = INT_BITS + FRACTION_BITS;
    localparam int CFG_W          = 9;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(14);

    typedef logic [PRICE_BITS-1:0] t_price;

    typedef struct packed {
        logic               start_series;
        logic [FIELD_W-1:0] bar_high;
        logic [FIELD_W-1:0] bar_low;
        logic [FIELD_W-1:0] bar_close;
    } t_bar_item;

    typedef struct packed {
        logic [OUT_W-1:0]   plus_vi;
        logic [OUT_W-1:0]   minus_vi;
        logic               flat_window;
        logic               saturated;
        logic [FIELD_W-1:0] bar_index;
    } t_vi_item;

    typedef struct packed {
        t_price tr;
        t_price vmp;
        t_price vmm;
    } t_terms;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TERM,
        S_SUM,
        S_UPDATE,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    function automatic t_price absdiff(input t_price a, input t_price b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // zero means one, anything past the ring depth means the ring depth
    function automatic logic [CFG_W-1:0] eff_window(input logic [CFG_W-1:0] wl,
                                                    input int max_win);
        logic [CFG_W-1:0] res;
        if (wl == '0) begin
            res = CFG_W'(1);
        end else if (int'(wl) > max_win) begin
            res = CFG_W'(max_win);
        end else begin
            res = wl;
        end
        return res;
    endfunction

endpackage

// ===== design/vortex_indicator.sv =====
// vortex indicator: a bar is taken only in idle; a first bar of a series is only stored, other
// bars pass the term, sum and update states and, with a full window, load and emit; a ratio is
// formed by the bit-serial divider (one quotient bit per cycle, 20 bits, run once for +VI and
// once for -VI) between load and emit, and emit waits until the output register is free
// reset (i_rst_n, synchronous, active low) clears the sequencer, history and
// output valid and sets the window to 14; ring entries are not cleared
module vortex_indicator
    import vi_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: window length
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // bar items in
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_bar_item        i_in_data,
    // indicator items out
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_vi_item         o_out_data
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int SUM_W  = PRICE_BITS + PTR_W;
    localparam int STEP_W = $clog2(OUT_W);

    // sequencer
    t_state r_state, n_state;

    // control state
    logic             r_have_prev;
    logic [CFG_W-1:0] r_win;
    logic [PTR_W-1:0] r_ptr;
    logic [CFG_W-1:0] r_count;
    logic             r_out_valid;

    // bar history and staging
    t_price           r_prev_hi, r_prev_lo, r_prev_cl;
    t_price           r_hi, r_lo, r_cl;
    logic [FIELD_W-1:0] r_bar_cnt, r_idx;

    // per-bar terms
    t_price           r_c0, r_c1, r_c2, r_tr, r_vmp, r_vmm;

    // rolling sums and the term ring
    logic [SUM_W-1:0] r_range_sum, r_plus_sum, r_minus_sum;
    t_terms           r_ring [MAX_WINDOW];
    t_terms           r_old;

    // bit-serial divider
    logic [SUM_W-1:0]  r_rem;
    logic [OUT_W-1:0]  r_shift;
    logic [STEP_W-1:0] r_step;
    logic              r_sel;      // 0: +VI numerator, 1: -VI numerator
    logic              r_sat, r_flat;
    logic [OUT_W-1:0]  r_plus, r_minus;
    t_vi_item          r_out;

    // handshakes
    logic in_fire, out_take, first_bar, emit_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;
    assign emit_free  = !r_out_valid || i_out_ready;
    // a new series starts on request or when nothing is held yet
    assign first_bar  = i_in_data.start_series || !r_have_prev;

    t_price in_hi, in_lo, in_cl;
    assign in_hi = i_in_data.bar_high[PRICE_BITS-1:0];
    assign in_lo = i_in_data.bar_low[PRICE_BITS-1:0];
    assign in_cl = i_in_data.bar_close[PRICE_BITS-1:0];

    // true range is the largest of the three candidates
    t_price m01, tr_max;
    assign m01    = (r_c0 >= r_c1) ? r_c0 : r_c1;
    assign tr_max = (m01 >= r_c2) ? m01 : r_c2;

    logic count_full, ptr_wrap;
    assign count_full = (r_count >= r_win);
    assign ptr_wrap   = ((int'(r_ptr) + 1) >= int'(r_win));

    // divider datapath: one restoring step per cycle
    logic [SUM_W-1:0] num_sel, num_top;
    logic             over;
    logic [SUM_W:0]   trial, diff;
    logic             fits, last_step;
    logic [OUT_W-1:0] quot_next;

    assign num_sel   = r_sel ? r_minus_sum : r_plus_sum;
    assign num_top   = num_sel >> INT_BITS;
    // integer part of 16 or more clips to full scale
    assign over      = (num_top >= r_range_sum);
    assign trial     = {r_rem, r_shift[OUT_W-1]};
    assign fits      = (trial >= {1'b0, r_range_sum});
    assign diff      = trial - {1'b0, r_range_sum};
    assign quot_next = {r_shift[OUT_W-2:0], fits};
    assign last_step = (r_step == STEP_W'(OUT_W - 1));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && !first_bar) begin
                    n_state = S_TERM;
                end
            end
            S_TERM:   n_state = S_SUM;
            S_SUM:    n_state = S_UPDATE;
            // count was bumped in the sum step; a full window gives an item
            S_UPDATE: n_state = count_full ? S_LOAD : S_IDLE;
            S_LOAD: begin
                if (r_range_sum == '0) begin
                    n_state = S_EMIT;
                end else if (over) begin
                    n_state = r_sel ? S_EMIT : S_LOAD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (last_step) begin
                    n_state = r_sel ? S_EMIT : S_LOAD;
                end
            end
            S_EMIT: begin
                if (emit_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_win       <= eff_window(WINDOW_RESET, MAX_WINDOW);
            r_ptr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= eff_window(i_cfg_wdata, MAX_WINDOW);
            end
            if (in_fire && first_bar) begin
                r_have_prev <= 1'b1;
                r_ptr       <= '0;
                r_count     <= '0;
            end else if (i_cfg_we) begin
                // a window write drops the series; the next bar starts afresh
                r_have_prev <= 1'b0;
            end
            if (r_state == S_SUM && !count_full) begin
                r_count <= r_count + CFG_W'(1);
            end
            if (r_state == S_UPDATE) begin
                r_ptr <= ptr_wrap ? '0 : r_ptr + PTR_W'(1);
            end
            if (r_state == S_EMIT && emit_free) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (first_bar) begin
                r_prev_hi   <= in_hi;
                r_prev_lo   <= in_lo;
                r_prev_cl   <= in_cl;
                r_bar_cnt   <= FIELD_W'(1);
                r_range_sum <= '0;
                r_plus_sum  <= '0;
                r_minus_sum <= '0;
            end else begin
                r_hi  <= in_hi;
                r_lo  <= in_lo;
                r_cl  <= in_cl;
                r_idx <= r_bar_cnt;
                if (r_bar_cnt != '1) begin
                    r_bar_cnt <= r_bar_cnt + FIELD_W'(1);
                end
            end
        end

        case (r_state)
            S_TERM: begin
                // inverted bar: high-low candidate counts as zero
                r_c0      <= (r_hi >= r_lo) ? (r_hi - r_lo) : '0;
                r_c1      <= absdiff(r_prev_cl, r_hi);
                r_c2      <= absdiff(r_prev_cl, r_lo);
                r_vmp     <= absdiff(r_hi, r_prev_lo);
                r_vmm     <= absdiff(r_lo, r_prev_hi);
                r_prev_hi <= r_hi;
                r_prev_lo <= r_lo;
                r_prev_cl <= r_cl;
            end
            S_SUM: begin
                r_tr <= tr_max;
                // oldest terms leave the window
                if (count_full) begin
                    r_range_sum <= r_range_sum - SUM_W'(r_old.tr);
                    r_plus_sum  <= r_plus_sum - SUM_W'(r_old.vmp);
                    r_minus_sum <= r_minus_sum - SUM_W'(r_old.vmm);
                end
            end
            S_UPDATE: begin
                r_range_sum <= r_range_sum + SUM_W'(r_tr);
                r_plus_sum  <= r_plus_sum + SUM_W'(r_vmp);
                r_minus_sum <= r_minus_sum + SUM_W'(r_vmm);
                r_sel       <= 1'b0;
                r_sat       <= 1'b0;
                r_flat      <= 1'b0;
            end
            S_LOAD: begin
                if (r_range_sum == '0) begin
                    r_flat  <= 1'b1;
                    r_plus  <= '0;
                    r_minus <= '0;
                end else if (over) begin
                    r_sat <= 1'b1;
                    if (r_sel) begin
                        r_minus <= '1;
                    end else begin
                        r_plus <= '1;
                    end
                    r_sel <= 1'b1;
                end else begin
                    // integer-part remainder, then the low numerator bits and zeros
                    r_rem   <= num_top;
                    r_shift <= {num_sel[INT_BITS-1:0], {FRACTION_BITS{1'b0}}};
                    r_step  <= '0;
                end
            end
            S_DIV: begin
                r_rem   <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                r_shift <= quot_next;
                r_step  <= r_step + STEP_W'(1);
                if (last_step) begin
                    if (r_sel) begin
                        r_minus <= quot_next;
                    end else begin
                        r_plus <= quot_next;
                    end
                    r_sel <= 1'b1;
                end
            end
            S_EMIT: begin
                if (emit_free) begin
                    r_out.plus_vi     <= r_plus;
                    r_out.minus_vi    <= r_minus;
                    r_out.flat_window <= r_flat;
                    r_out.saturated   <= r_sat;
                    r_out.bar_index   <= r_idx;
                end
            end
            default: begin
            end
        endcase
    end

    // term ring, registered read of the entry about to be replaced
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_ring[r_ptr] <= '{tr: r_tr, vmp: r_vmp, vmm: r_vmm};
        end
        r_old <= r_ring[r_ptr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ring pointer stays inside the active window
    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_prev |-> (int'(r_ptr) < int'(r_win)))
        else $error("ring pointer outside window");

    // term count never exceeds the window
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_prev |-> (r_count <= r_win))
        else $error("term count above window");

    // partial remainder stays below the true-range sum
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_range_sum))
        else $error("divider remainder out of range");

    // an item is only formed from a full window
    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count == r_win))
        else $error("item emitted before window full");

    // flat window forces zero ratios and no clipping
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.flat_window) |->
            (o_out_data.plus_vi == '0 && o_out_data.minus_vi == '0
             && !o_out_data.saturated))
        else $error("flat window item not zeroed");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for vortex_indicator (+VI / -VI over a rolling bar window)
// depends on vi_pkg for the bar and indicator item types and on design/vortex_indicator.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vi_pkg::*;

    // run limits and waits
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 60;      // covers the longest bar inside the block
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off to back the block up
    localparam int RAND_TOTAL    = 980;
    localparam int NUM_PHASES    = 8;
    localparam int PLAN_LEN      = 25;

    localparam logic [OUT_W-1:0]   VI_FULL = '1;
    localparam logic [OUT_W-1:0]   VI_ONE  = OUT_W'(1) << FRACTION_BITS;
    localparam logic [FIELD_W-1:0] P_TOP   = '1;

    typedef enum bit {ROW_BAR, ROW_CFG} t_row_kind;

    // one row of the directed plan: either a window write or a bar, with the
    // indicator item typed in where it is obvious, otherwise left to the predictor
    typedef struct {
        t_row_kind        kind;
        logic [CFG_W-1:0] wl;
        logic             start;
        logic [31:0]      hi;
        logic [31:0]      lo;
        logic [31:0]      cl;
        bit               typed;
        bit               has_res;
        logic [OUT_W-1:0] pv;
        logic [OUT_W-1:0] mv;
        logic             fl;
        logic             st;
        logic [31:0]      ix;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_bar_item        i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_vi_item         o_out_data;

    vortex_indicator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: previous bar, term rings and running sums
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] win_reg;
    logic [31:0]      last_hi, last_lo, last_cl;
    bit               primed;
    logic [31:0]      ring_tr [MAX_WINDOW_DEF];
    logic [31:0]      ring_up [MAX_WINDOW_DEF];
    logic [31:0]      ring_dn [MAX_WINDOW_DEF];
    int unsigned      slot, filled;
    logic [39:0]      tr_total, up_total, dn_total;
    logic [31:0]      bars_seen;

    t_vi_item         vi_expected [$];   // indicator items still owed by the block
    t_vi_item         vi_want;

    int               errors = 0;
    int               bars_sent = 0;
    int               vi_checked = 0;
    int               flat_seen = 0;
    int               clip_seen = 0;
    int unsigned      cycles = 0;

    // idling knobs, read by the bar sender and the indicator receiver
    int               snd_idle_pct = 0;
    int               rcv_idle_pct = 0;
    bit               hold_req = 1'b0;
    int               hold_left = 0;

    // random bar generator state
    logic [31:0]      mid;
    int unsigned      spread;

    function automatic logic [31:0] gap_between(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void forget_series();
        last_hi   = '0;
        last_lo   = '0;
        last_cl   = '0;
        primed    = 1'b0;
        slot      = 0;
        filled    = 0;
        tr_total  = '0;
        up_total  = '0;
        dn_total  = '0;
        bars_seen = '0;
    endfunction

    // floor(num * 2^FRACTION_BITS / den) in Q4.16, clipped at full scale
    function automatic logic [OUT_W-1:0] vi_ratio(input logic [39:0] num,
                                                  input logic [39:0] den,
                                                  inout bit clip);
        logic [63:0] whole, rest, frac;
        whole = 64'(num) / 64'(den);
        rest  = 64'(num) % 64'(den);
        if (whole >= (64'd1 << INT_BITS)) begin
            clip = 1'b1;
            return VI_FULL;
        end
        frac = (rest << FRACTION_BITS) / 64'(den);
        return OUT_W'((whole << FRACTION_BITS) | frac);
    endfunction

    // advance the predictor by one bar; returns 1 when an indicator item is due
    function automatic bit vortex_next(input t_bar_item b, output t_vi_item r);
        logic [31:0] hi, lo, cl, tr, up, dn, d;
        int unsigned w;
        bit          clip;
        hi   = b.bar_high;
        lo   = b.bar_low;
        cl   = b.bar_close;
        clip = 1'b0;
        r    = '0;
        // zero acts as one, past the ring depth acts as the ring depth
        if (win_reg == '0) w = 1;
        else if (int'(win_reg) > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
        else w = int'(win_reg);

        // first bar of a series only seeds the previous-bar registers
        if (b.start_series || !primed) begin
            forget_series();
            last_hi   = hi;
            last_lo   = lo;
            last_cl   = cl;
            primed    = 1'b1;
            bars_seen = 32'd1;
            return 1'b0;
        end

        r.bar_index = bars_seen;
        if (bars_seen != '1) bars_seen = bars_seen + 1;

        // inverted bar contributes nothing from its own span
        tr = (hi >= lo) ? hi - lo : '0;
        d  = gap_between(last_cl, hi);
        if (d > tr) tr = d;
        d  = gap_between(last_cl, lo);
        if (d > tr) tr = d;
        up = gap_between(hi, last_lo);
        dn = gap_between(lo, last_hi);
        last_hi = hi;
        last_lo = lo;
        last_cl = cl;

        slot = slot % MAX_WINDOW_DEF;
        if (filled >= w) begin
            tr_total = tr_total - 40'(ring_tr[slot]);
            up_total = up_total - 40'(ring_up[slot]);
            dn_total = dn_total - 40'(ring_dn[slot]);
        end else begin
            filled++;
        end
        ring_tr[slot] = tr;
        ring_up[slot] = up;
        ring_dn[slot] = dn;
        tr_total = tr_total + 40'(tr);
        up_total = up_total + 40'(up);
        dn_total = dn_total + 40'(dn);
        slot++;
        if (slot >= w) slot = 0;

        if (filled < w) return 1'b0;

        if (tr_total == '0) begin
            r.flat_window = 1'b1;
        end else begin
            r.plus_vi  = vi_ratio(up_total, tr_total, clip);
            r.minus_vi = vi_ratio(dn_total, tr_total, clip);
        end
        r.saturated = clip;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // bar sender: called at a falling edge, returns at the falling edge
    // after the item was taken
    // ------------------------------------------------------------------
    task automatic put_bar(input t_bar_item b, input bit typed, input bit has_res,
                           input t_vi_item res);
        t_vi_item pred;
        bit       due;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // taken at this edge
        bars_sent++;
        due = vortex_next(b, pred);
        if (typed) begin
            if (has_res) vi_expected.push_back(res);
        end else if (due) begin
            vi_expected.push_back(pred);
        end
        @(negedge i_clk);
    endtask

    // stop offering bars and wait until every owed indicator item has come
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (vi_expected.size() != 0) @(negedge i_clk);
    endtask

    // window writes only with the block idle: drained, plus time for a
    // result-less bar that may still be in flight
    task automatic set_window(input logic [CFG_W-1:0] wl);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wl;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        // a window write also throws away the series
        win_reg = wl;
        forget_series();
    endtask

    // mostly well-formed price walks, with flat runs, long lower tails,
    // raw random bars, inverted bars and the odd mid-phase series restart
    function automatic t_bar_item make_bar(input bit first);
        t_bar_item   b;
        int unsigned pick;
        logic [31:0] half;
        pick = $urandom_range(0, 99);
        b.start_series = first || (pick < 2);
        if (pick < 72) begin
            mid  = mid + $urandom_range(0, 2 * spread) - spread;
            half = $urandom_range(0, spread);
            b.bar_high  = mid + half;
            b.bar_low   = mid - half;
            b.bar_close = b.bar_low + $urandom_range(0, 2 * half);
        end else if (pick < 82) begin
            // repeated identical bars drive the window flat
            b.bar_high  = mid;
            b.bar_low   = mid;
            b.bar_close = mid;
        end else if (pick < 90) begin
            // long tail below, then narrow bars push the ratios toward clipping
            b.bar_high  = mid;
            b.bar_low   = mid - $urandom_range(spread, 64 * spread);
            b.bar_close = mid;
        end else if (pick < 97) begin
            b.bar_high  = $urandom;
            b.bar_low   = $urandom;
            b.bar_close = $urandom;
        end else begin
            b.bar_high  = mid - $urandom_range(1, spread);
            b.bar_low   = mid + $urandom_range(1, spread);
            b.bar_close = mid;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // directed plan
    // ------------------------------------------------------------------
    t_plan_row plan [PLAN_LEN] = '{
        // no bar held after reset, then window 14 still filling
        '{ROW_BAR, 9'd0, 1'b0, 32'd10, 32'd20, 32'd30, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd40, 32'd5, 32'd20, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_CFG, 9'd1, 1'b0, 0, 0, 0, 0, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b1, 32'd100, 32'd50, 32'd75, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd200, 32'd100, 32'd150, 0, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd120, 32'd90, 32'd95, 0, 0, '0, '0, 0, 0, 0},
        // flat window
        '{ROW_BAR, 9'd0, 1'b1, 32'd5, 32'd5, 32'd5, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd5, 32'd5, 32'd5, 1, 1, '0, '0, 1, 0, 1},
        // +VI clipped
        '{ROW_BAR, 9'd0, 1'b1, 32'd1000, 32'd0, 32'd1000, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd1001, 32'd1000, 32'd1000, 1, 1, VI_FULL, '0, 0, 1, 1},
        // -VI clipped, +VI exactly one
        '{ROW_BAR, 9'd0, 1'b1, 32'd9000, 32'd1000, 32'd1000, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd1001, 32'd1000, 32'd1000, 1, 1, VI_ONE, VI_FULL, 0, 1, 1},
        // price extremes, then an inverted bar at full span
        '{ROW_BAR, 9'd0, 1'b1, P_TOP, 32'd0, P_TOP, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, P_TOP, P_TOP, P_TOP, 1, 1, '0, '0, 1, 0, 1},
        '{ROW_BAR, 9'd0, 1'b0, 32'd0, P_TOP, 32'd0, 1, 1, VI_ONE, '0, 0, 0, 2},
        '{ROW_BAR, 9'd0, 1'b0, 32'd0, 32'd0, 32'd0, 0, 0, '0, '0, 0, 0, 0},
        // window write drops the series: first bar seeds, second still fills
        '{ROW_CFG, 9'd2, 1'b0, 0, 0, 0, 0, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd300, 32'd200, 32'd250, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd310, 32'd240, 32'd260, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd330, 32'd250, 32'd320, 0, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd320, 32'd280, 32'd300, 0, 0, '0, '0, 0, 0, 0},
        // zero window acts as one
        '{ROW_CFG, 9'd0, 1'b0, 0, 0, 0, 0, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd7, 32'd3, 32'd5, 1, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd9, 32'd1, 32'd4, 0, 0, '0, '0, 0, 0, 0},
        '{ROW_BAR, 9'd0, 1'b0, 32'd2, 32'd2, 32'd9, 0, 0, '0, '0, 0, 0, 0}
    };

    // window settings of the random part, with bars per setting; 511 and
    // 256 both land on the full ring depth
    int phase_wl  [NUM_PHASES] = '{3, 1, 14, 2, 511, 0, 256, 5};
    int phase_len [NUM_PHASES] = '{110, 120, 120, 100, 280, 90, 60, 100};

    // ------------------------------------------------------------------
    // indicator receiver: ready changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // every taken indicator item against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vi_expected.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, got plus 0x%0h minus 0x%0h idx %0d",
                         $time, o_out_data.plus_vi, o_out_data.minus_vi,
                         o_out_data.bar_index);
                errors++;
            end else begin
                vi_want = vi_expected.pop_front();
                vi_checked++;
                if (vi_want.flat_window) flat_seen++;
                if (vi_want.saturated) clip_seen++;
                compare_field("plus_vi", 32'(vi_want.plus_vi), 32'(o_out_data.plus_vi));
                compare_field("minus_vi", 32'(vi_want.minus_vi), 32'(o_out_data.minus_vi));
                compare_field("flat_window", 32'(vi_want.flat_window),
                              32'(o_out_data.flat_window));
                compare_field("saturated", 32'(vi_want.saturated), 32'(o_out_data.saturated));
                compare_field("bar_index", vi_want.bar_index, o_out_data.bar_index);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_bar_item b;
        t_vi_item  r;
        int        done_rand;
        win_reg = WINDOW_RESET;
        forget_series();
        done_rand = 0;

        // synchronous reset, released at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows, sender rarely idles, receiver often
        snd_idle_pct = 19;
        rcv_idle_pct = 85;
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                set_window(plan[k].wl);
            end else begin
                b.start_series = plan[k].start;
                b.bar_high     = plan[k].hi;
                b.bar_low      = plan[k].lo;
                b.bar_close    = plan[k].cl;
                r.plus_vi      = plan[k].pv;
                r.minus_vi     = plan[k].mv;
                r.flat_window  = plan[k].fl;
                r.saturated    = plan[k].st;
                r.bar_index    = plan[k].ix;
                put_bar(b, plan[k].typed, plan[k].has_res, r);
            end
        end

        // random part, one window setting per phase
        r = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_window(CFG_W'(phase_wl[p]));
            mid    = $urandom;
            spread = 1 << $urandom_range(2, 12);
            // with window one every bar but a series' first gives an item, so a long receiver
            // hold-off here backs the block up into its input
            if (phase_wl[p] == 1) hold_req = 1'b1;
            for (int n = 0; n < phase_len[p]; n++) begin
                // sender rarely idles then often, then nobody idles
                if (done_rand < RAND_TOTAL / 3) begin
                    snd_idle_pct = 19;
                    rcv_idle_pct = 85;
                end else if (done_rand < 2 * RAND_TOTAL / 3) begin
                    snd_idle_pct = 85;
                    rcv_idle_pct = 19;
                end else begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
                // sender pauses mid-phase until the block has caught up
                if (phase_wl[p] == 14 && n == 60) drain_results();
                b = make_bar(n == 0);
                put_bar(b, 1'b0, 1'b0, r);
                done_rand++;
            end
        end

        // wind down: everything owed, then a quiet stretch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run: %0d bars over %0d window settings, %0d indicator items checked",
                 bars_sent, NUM_PHASES + 3, vi_checked);
        $display("     %0d flat windows, %0d clipped ratios, %0d mismatches",
                 flat_seen, clip_seen, errors);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
